/* design/nclu_pkg.sv */
package nclu_pkg;

  // Field widths of the request and result channels
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int WAY_OUT_W  = 2;
  localparam int SET_OUT_W  = 6;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_PAD_W  = 7;
  localparam int OUT_TDATA_W = 1 + WAY_OUT_W + SET_OUT_W + OUT_PAD_W;

  // Configuration register widths and limits
  localparam int OFFSET_W     = 5;
  localparam int INDEX_W      = 3;
  localparam int SHIFT_W      = 6;
  localparam int MAX_INDEX    = 6;
  localparam int RAW_SETS     = 64;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd0;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 3'd6;

  // Register select: bit 2 of the byte address
  localparam logic REG_OFFSET_BITS = 1'b0;
  localparam logic REG_INDEX_BITS  = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset_bits;
    logic [INDEX_W-1:0]  index_bits;
  } nclu_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE
  } nclu_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } nclu_cmd_t;

  typedef struct packed {
    logic out_free;
  } nclu_sts_t;

endpackage

/* design/nru_cache_lookup_top.sv */
// Tag lookup of a set-associative cache with not-recently-used replacement.
// Input stream (in_*): one request per access address in in_tdata. The set is
// the index bits just above the block offset; the tag is the bits above that.
// Result stream (out_*): one result per request: hit flag, the way that hit or
// was filled, and the set.
// Configuration (cfg_*): offset_bits at byte address 0, index_bits at 4.
// Write only while no request is in flight.
// Timing: the accepting edge captures the address, the set row is then read
// from the single-port row memory into a register, and the last step compares
// all ways, writes the row back and loads the result, raising out_tvalid. A new
// request is taken only once the previous request has loaded its result; it is
// accepted while an earlier result still waits.
// Stall: while out_tready is low the result holds; a finished update waits
// for the output register, and in_tready stays low meanwhile.
// Reset: all ways read as invalid with NRU bits set (per-set row flags are
// cleared at once, no clearing pass); offset_bits resets to 0, index_bits to 6.
module nru_cache_lookup_top #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [nclu_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] access_addr
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nclu_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [0] hit, [2:1] way_used,
                                                          // [8:3] set_used, [15:9] zero
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [nclu_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [nclu_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [nclu_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  nclu_pkg::nclu_cfg_t cfg;
  nclu_pkg::nclu_cmd_t cmd;
  nclu_pkg::nclu_sts_t sts;

  nclu_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  nclu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nclu_dp #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* design/nclu_cfg.sv */
module nclu_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [nclu_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [nclu_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [nclu_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready,
  output nclu_pkg::nclu_cfg_t               cfg
);

  logic [nclu_pkg::OFFSET_W-1:0] offset_bits_r;
  logic [nclu_pkg::INDEX_W-1:0]  index_bits_r;
  logic                          wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Write the selected register at the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= nclu_pkg::OFFSET_RST;
      index_bits_r  <= nclu_pkg::INDEX_RST;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        nclu_pkg::REG_OFFSET_BITS: offset_bits_r <= cfg_pwdata[nclu_pkg::OFFSET_W-1:0];
        nclu_pkg::REG_INDEX_BITS:  index_bits_r  <= cfg_pwdata[nclu_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      nclu_pkg::REG_OFFSET_BITS: cfg_prdata[nclu_pkg::OFFSET_W-1:0] = offset_bits_r;
      nclu_pkg::REG_INDEX_BITS:  cfg_prdata[nclu_pkg::INDEX_W-1:0]  = index_bits_r;
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg.offset_bits = offset_bits_r;
  assign cfg.index_bits  = index_bits_r;

endmodule

/* design/nclu_ctrl.sv */
module nclu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  nclu_pkg::nclu_sts_t  sts,
  output nclu_pkg::nclu_cmd_t  cmd
);

  nclu_pkg::nclu_state_t state_r;
  nclu_pkg::nclu_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nclu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Take a request, read its set row, then update the row and load the result
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      nclu_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = nclu_pkg::ST_READ;
        end
      end
      nclu_pkg::ST_READ: begin
        state_nxt = nclu_pkg::ST_DECIDE;
      end
      nclu_pkg::ST_DECIDE: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = nclu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nclu_pkg::ST_IDLE;
    endcase
  end

endmodule

/* design/nclu_dp.sv */
module nclu_dp #(
  parameter int SETS      = 64,
  parameter int WAYS      = 4,
  parameter int ADDR_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nclu_pkg::nclu_cfg_t                 cfg,
  input  nclu_pkg::nclu_cmd_t                 cmd,
  output nclu_pkg::nclu_sts_t                 sts,
  input  logic [nclu_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nclu_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW    = (ADDR_BITS < nclu_pkg::ADDR_W) ? ADDR_BITS : nclu_pkg::ADDR_W;
  localparam logic [nclu_pkg::ADDR_W-1:0] AMASK =
    nclu_pkg::ADDR_W'((64'd1 << AW) - 64'd1);

  // Set row storage: tags, and flags {nru, valid}
  logic [WAYS-1:0][nclu_pkg::TAG_W-1:0] tag_mem  [SETS];
  logic [2*WAYS-1:0]                    flag_mem [SETS];
  logic [SETS-1:0]                      row_ok_r;

  logic [nclu_pkg::ADDR_W-1:0]          addr_r;
  logic [WAYS-1:0][nclu_pkg::TAG_W-1:0] rd_tag_r;
  logic [2*WAYS-1:0]                    rd_flag_r;
  logic                                 rd_ok_r;

  logic [nclu_pkg::INDEX_W-1:0]         ib;
  logic [nclu_pkg::SHIFT_W-1:0]         tag_shift;
  logic [nclu_pkg::ADDR_W-1:0]          off_addr;
  logic [nclu_pkg::SET_OUT_W-1:0]       raw_set;
  logic [SET_W-1:0]                     set_tab [nclu_pkg::RAW_SETS];
  logic [SET_W-1:0]                     set_idx;
  logic [nclu_pkg::TAG_W-1:0]           tag;

  logic [WAYS-1:0]                      valid_cur;
  logic [WAYS-1:0]                      nru_cur;
  logic [WAYS-1:0]                      hit_vec;
  logic                                 hit;
  logic [WAY_W-1:0]                     hit_way;
  logic [WAY_W-1:0]                     nru_way;
  logic [WAY_W-1:0]                     way;
  logic [WAYS-1:0]                      valid_nxt;
  logic [WAYS-1:0]                      nru_nxt;
  logic [WAYS-1:0][nclu_pkg::TAG_W-1:0] tag_row_nxt;
  logic [WAY_W+nclu_pkg::WAY_OUT_W-1:0] way_ext;
  logic [SET_W+nclu_pkg::SET_OUT_W-1:0] set_ext;

  logic                                 out_valid_r;
  logic                                 out_hit_r;
  logic [nclu_pkg::WAY_OUT_W-1:0]       out_way_r;
  logic [nclu_pkg::SET_OUT_W-1:0]       out_set_r;

  // Capture the access address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_tdata & AMASK;
    end
  end

  // Split the address into set and tag
  assign ib        = (cfg.index_bits > nclu_pkg::INDEX_W'(nclu_pkg::MAX_INDEX)) ?
                     nclu_pkg::INDEX_W'(nclu_pkg::MAX_INDEX) : cfg.index_bits;
  assign tag_shift = nclu_pkg::SHIFT_W'(cfg.offset_bits) + nclu_pkg::SHIFT_W'(ib);
  assign off_addr  = addr_r >> cfg.offset_bits;
  assign raw_set   = off_addr[nclu_pkg::SET_OUT_W-1:0] &
                     ~(nclu_pkg::SET_OUT_W'(6'h3F) << ib);
  assign tag       = addr_r >> tag_shift;

  // Reduce the raw index to the sets present
  for (genvar g = 0; g < nclu_pkg::RAW_SETS; g++) begin : g_set_tab
    assign set_tab[g] = SET_W'(g % SETS);
  end
  assign set_idx = set_tab[raw_set];

  // Read the set row every cycle, write it back on commit
  always_ff @(posedge clk) begin
    rd_tag_r  <= tag_mem[set_idx];
    rd_flag_r <= flag_mem[set_idx];
    if (cmd.commit) begin
      tag_mem[set_idx]  <= tag_row_nxt;
      flag_mem[set_idx] <= {nru_nxt, valid_nxt};
    end
  end

  // Rows never written read as reset: no valid way, all NRU bits set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      rd_ok_r  <= 1'b0;
    end else begin
      rd_ok_r <= row_ok_r[set_idx];
      if (cmd.commit) begin
        row_ok_r[set_idx] <= 1'b1;
      end
    end
  end

  assign valid_cur = rd_ok_r ? rd_flag_r[WAYS-1:0]      : '0;
  assign nru_cur   = rd_ok_r ? rd_flag_r[2*WAYS-1:WAYS] : '1;

  // Compare all ways, pick the lowest hit and the lowest NRU way
  always_comb begin
    hit_way = '0;
    nru_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_cur[w] && (rd_tag_r[w] == tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (nru_cur[w]) begin
        nru_way = WAY_W'(w);
      end
    end
    hit = |hit_vec;
  end

  // Build the updated row
  always_comb begin
    tag_row_nxt = rd_tag_r;
    valid_nxt   = valid_cur;
    nru_nxt     = nru_cur;
    if (hit) begin
      way = hit_way;
    end else begin
      // when no NRU bit is set, way 0 is chosen after setting them all
      way = (|nru_cur) ? nru_way : '0;
      if (!(|nru_cur)) begin
        nru_nxt = '1;
      end
      tag_row_nxt[way] = tag;
      valid_nxt[way]   = 1'b1;
    end
    nru_nxt[way] = 1'b0;
  end

  assign way_ext = {{nclu_pkg::WAY_OUT_W{1'b0}}, way};
  assign set_ext = {{nclu_pkg::SET_OUT_W{1'b0}}, set_idx};

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r <= hit;
      out_way_r <= way_ext[nclu_pkg::WAY_OUT_W-1:0];
      out_set_r <= set_ext[nclu_pkg::SET_OUT_W-1:0];
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{nclu_pkg::OUT_PAD_W{1'b0}}, out_set_r, out_way_r, out_hit_r};

endmodule

/* sim/nclu_lookup_checker.sv */
`timescale 1ns / 100ps

module nclu_lookup_checker #(
  parameter int NWAYS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [nclu_pkg::IN_TDATA_W-1:0]   in_tdata,   // [31:0] access_addr
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [nclu_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [0] hit, [2:1] way_used,
                                                        // [8:3] set_used, [15:9] zero
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [nclu_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [nclu_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input  logic [nclu_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  input  logic                              cfg_pready,
  output int                                fail_count,
  output int                                outstanding,
  output int                                access_count,
  output int                                hit_count,
  output int                                refill_count
);
  import nclu_pkg::*;

  localparam int ENTRIES = RAW_SETS * NWAYS;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_idx;
    logic [SET_OUT_W-1:0] set_idx;
  } lookup_t;

  // Shadow copy of the tag store and the registers
  logic [TAG_W-1:0]    tag_mem   [ENTRIES];
  logic                valid_mem [ENTRIES];
  logic                nru_mem   [ENTRIES];
  logic [OFFSET_W-1:0] cfg_offset;
  logic [INDEX_W-1:0]  cfg_index;
  lookup_t             expected_lookups [$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    access_count = 0;
    hit_count    = 0;
    refill_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Look up one address and update the shadow store with NRU replacement
  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [63:0]      wide_addr;
    logic [63:0]      field;
    logic [TAG_W-1:0] tag;
    int unsigned      ib;
    int unsigned      base;
    int unsigned      slot;
    bit               found;
    lookup_t          r;
    wide_addr = {32'd0, addr};
    // index widths above MAX_INDEX saturate
    ib = (cfg_index > MAX_INDEX) ? MAX_INDEX : cfg_index;
    field = (wide_addr >> cfg_offset) & ((64'd1 << ib) - 64'd1);
    r.set_idx = field[SET_OUT_W-1:0];
    // bits shifted past the address read as zero
    field = wide_addr >> (cfg_offset + ib);
    tag = field[TAG_W-1:0];
    base = r.set_idx * NWAYS;
    r.hit = 1'b0;
    r.way_idx = '0;
    found = 1'b0;
    for (int w = 0; w < NWAYS; w++) begin
      if (!found && valid_mem[base + w] && tag_mem[base + w] == tag) begin
        found = 1'b1;
        r.hit = 1'b1;
        r.way_idx = WAY_OUT_W'(w);
        nru_mem[base + w] = 1'b0;
      end
    end
    if (!found) begin
      for (int w = 0; w < NWAYS; w++) begin
        if (!found && nru_mem[base + w]) begin
          found = 1'b1;
          r.way_idx = WAY_OUT_W'(w);
        end
      end
      // every way recently used: mark the whole set, then take way 0
      if (!found) begin
        for (int w = 0; w < NWAYS; w++) nru_mem[base + w] = 1'b1;
        r.way_idx = '0;
        refill_count++;
      end
      slot = base + r.way_idx;
      tag_mem[slot] = tag;
      valid_mem[slot] = 1'b1;
      nru_mem[slot] = 1'b0;
    end
    else begin
      hit_count++;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    lookup_t got;
    logic [CFG_DATA_W-1:0] reg_val;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_mem[i] = '0;
        valid_mem[i] = 1'b0;
        nru_mem[i] = 1'b1;
      end
      cfg_offset = OFFSET_RST;
      cfg_index = INDEX_RST;
      expected_lookups.delete();
      outstanding <= 0;
    end
    else begin
      // compare a finished result with the oldest request
      if (out_tvalid && out_tready) begin
        got.hit = out_tdata[0];
        got.way_idx = out_tdata[WAY_OUT_W:1];
        got.set_idx = out_tdata[WAY_OUT_W+SET_OUT_W:WAY_OUT_W+1];
        if (expected_lookups.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with no request outstanding", out_tdata));
        end
        else begin
          want = expected_lookups.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit expected %0d got %0d", want.hit, got.hit));
          if (got.way_idx !== want.way_idx)
            report_mismatch($sformatf("way_used expected %0d got %0d",
                                      want.way_idx, got.way_idx));
          if (got.set_idx !== want.set_idx)
            report_mismatch($sformatf("set_used expected %0d got %0d",
                                      want.set_idx, got.set_idx));
        end
      end
      // predict each accepted request
      if (in_tvalid && in_tready) begin
        access_count++;
        want = predict_lookup(in_tdata);
        expected_lookups = {expected_lookups, want};
      end
      // track register writes, check readback
      if (cfg_psel && cfg_penable && cfg_pready) begin
        reg_val = (cfg_paddr[2] == REG_INDEX_BITS) ? 32'(cfg_index) : 32'(cfg_offset);
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_OFFSET_BITS) cfg_offset = cfg_pwdata[OFFSET_W-1:0];
          else cfg_index = cfg_pwdata[INDEX_W-1:0];
        end
        else if (cfg_prdata !== reg_val) begin
          report_mismatch($sformatf("register at 0x%0h read 0x%0h, expected 0x%0h",
                                    cfg_paddr, cfg_prdata, reg_val));
        end
      end
      outstanding <= expected_lookups.size();
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import nclu_pkg::*;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS    = 160;
  localparam int N_PHASES       = 9;
  localparam int N_DIRECTED     = 15;
  localparam logic [CFG_ADDR_W-1:0] OFFSET_ADDR = {REG_OFFSET_BITS, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] INDEX_ADDR  = {REG_INDEX_BITS, 2'b00};

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_tvalid   = 1'b0;
  logic [IN_TDATA_W-1:0]   in_tdata    = '0;
  logic                    out_tready  = 1'b0;
  logic                    cfg_psel    = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]   cfg_pwdata  = '0;
  logic                    in_tready;
  logic                    out_tvalid;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [CFG_DATA_W-1:0]   cfg_prdata;
  logic                    cfg_pready;

  int fail_count;
  int outstanding;
  int access_count;
  int hit_count;
  int refill_count;

  // idling controls and the long receiver hold-off
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_hold_req  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int settings_count = 0;

  logic [OFFSET_W-1:0] cur_offset = OFFSET_RST;
  logic [INDEX_W-1:0]  cur_index  = INDEX_RST;
  logic [ADDR_W-1:0]   tag_pool [6];
  logic [ADDR_W-1:0]   directed_addrs [N_DIRECTED];

  int ph_offset [N_PHASES] = '{4, 0, 31, 24, 2, 12, 0, 6, 28};
  int ph_index  [N_PHASES] = '{3, 0, 7, 6, 2, 5, 6, 1, 4};
  int ph_tx     [N_PHASES] = '{0, 85, 0, 30, 0, 30, 85, 0, 30};
  int ph_rx     [N_PHASES] = '{0, 0, 85, 30, 0, 30, 0, 85, 30};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  nru_cache_lookup_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  nclu_lookup_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .access_count (access_count),
    .hit_count    (hit_count),
    .refill_count (refill_count)
  );

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end
    else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end
    else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // One APB transfer: setup, access, then idle
  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers with junk in the unused bits, then read them back
  task automatic apply_settings(input int offset, input int index);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    cur_offset = OFFSET_W'(offset);
    cur_index = INDEX_W'(index);
    cfg_access(1'b1, OFFSET_ADDR, {junk[CFG_DATA_W-1:OFFSET_W], cur_offset});
    cfg_access(1'b1, INDEX_ADDR, {junk[CFG_DATA_W-1:INDEX_W], cur_index});
    cfg_access(1'b0, OFFSET_ADDR, '0);
    cfg_access(1'b0, INDEX_ADDR, '0);
    settings_count++;
  endtask

  // Offer one request, idling first at the sender's rate
  task automatic send_access(input logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly reused tags in a few sets, so ways hit, fill and get evicted
  function automatic logic [ADDR_W-1:0] make_addr();
    logic [63:0] a;
    int unsigned ib;
    int unsigned pick;
    ib = (cur_index > MAX_INDEX) ? MAX_INDEX : cur_index;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom;
    if (pick < 20) begin
      case ($urandom_range(3))
        0: return '0;
        1: return '1;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    a = ({32'd0, tag_pool[$urandom_range(5)]} << (cur_offset + ib))
        | (64'($urandom_range(3)) << cur_offset)
        | ({32'd0, $urandom} & ((64'd1 << cur_offset) - 64'd1));
    return a[ADDR_W-1:0];
  endfunction

  initial begin
    // set 0 filled, overfilled and revisited; set 63 and bit patterns at the edges
    directed_addrs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0040, 32'h0000_0080,
                       32'h0000_00C0, 32'h0000_0000, 32'h0000_0100, 32'h0000_0040,
                       32'h0000_0000, 32'hFFFF_FFC0, 32'hFFFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, directed lookups
    cfg_access(1'b0, OFFSET_ADDR, '0);
    cfg_access(1'b0, INDEX_ADDR, '0);
    settings_count = 1;
    foreach (directed_addrs[i]) send_access(directed_addrs[i]);
    drain();

    // random phases over register settings and idling modes
    for (int p = 0; p < N_PHASES; p++) begin
      apply_settings(ph_offset[p], ph_index[p]);
      foreach (tag_pool[i]) tag_pool[i] = (i < 3) ? i : $urandom;
      tx_idle_pct <= ph_tx[p];
      rx_stall_pct <= ph_rx[p];
      if (p == 4) rx_hold_req <= rx_hold_req + 1;
      repeat (PHASE_ITEMS) send_access(make_addr());
      drain();
    end

    $display("Summary: %0d lookups under %0d register settings, %0d hits, %0d misses",
             access_count, settings_count, hit_count, access_count - hit_count);
    $display("Summary: %0d full-set NRU resets, one %0d-cycle result hold-off",
             refill_count, RX_HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("nru_cache_lookup_top test passed");
    end
    else begin
      $display("nru_cache_lookup_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("nru_cache_lookup_top test failed");
    $finish;
  end

endmodule

/* files.f */
design/nclu_pkg.sv
design/nclu_cfg.sv
design/nclu_ctrl.sv
design/nclu_dp.sv
design/nru_cache_lookup_top.sv
sim/nclu_lookup_checker.sv
sim/tb_top.sv
